// File: hw/rtl/hjr_pkg.sv
`default_nettype none
package hjr_pkg;

   localparam int BUTTON_BITS     = 8;
   localparam int NUM_BUTTONS_DEF = 8;
   localparam int NUM_AXES        = 6;
   localparam int AXIS_IN_W       = 16;
   localparam int AXIS_OUT_W      = 8;
   localparam int AXIS_SUM_W      = AXIS_IN_W + 1;
   localparam int CMD_W           = 3;
   localparam int STATUS_W        = 2;
   localparam int REQ_DATA_W      = 2 * BUTTON_BITS + NUM_AXES * AXIS_IN_W;
   localparam int RSP_DATA_W      = 64;

   typedef logic [CMD_W-1:0]       cmd_type;
   typedef logic [STATUS_W-1:0]    status_type;
   typedef logic [BUTTON_BITS-1:0] button_byte_type;
   typedef logic [7:0]             count_type;

   localparam cmd_type CMD_PRESS        = 3'd0;
   localparam cmd_type CMD_RELEASE      = 3'd1;
   localparam cmd_type CMD_PRESS_MASK   = 3'd2;
   localparam cmd_type CMD_RELEASE_MASK = 3'd3;
   localparam cmd_type CMD_SET_AXES     = 3'd4;
   localparam cmd_type CMD_ADD_AXES     = 3'd5;
   localparam cmd_type CMD_CLEAR        = 3'd6;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_BAD_INDEX = 2'd1;
   localparam status_type STATUS_UNDERFLOW = 2'd2;

   localparam logic signed [AXIS_SUM_W-1:0] AXIS_MAX = 17'sd127;
   localparam logic signed [AXIS_SUM_W-1:0] AXIS_MIN = -17'sd127;

   localparam count_type COUNT_MAX = 8'hFF;

   // What one button lane reports to the merge stage.
   typedef struct packed {
      logic held;
      logic success;
      logic underflow;
   } btn_result_type;

endpackage
`default_nettype wire

// File: hw/rtl/hid_joystick_report_accumulator_core.sv
`default_nettype none
// Channel   Ports                     Carries
// request   req_tvalid/tready/tdata   one command word per item, command in tuser
// response  rsp_tvalid/tready/tdata   the report after that item and a status
//
// One word is taken per cycle while req_tready is high; its response is registered.
// The button lanes, axis lanes and merge stage are combinational.
// A two-entry output stage (register plus skid) keeps req_tready registered, so a
// stalled response side stops intake only once both entries are full.
// Synchronous reset clears the press counts, held mask, report and output stage.
module hid_joystick_report_accumulator_core #(
   parameter int NUM_BUTTONS = hjr_pkg::NUM_BUTTONS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // button_index, button_mask, axis_x, axis_y, axis_z, axis_rx, axis_ry, axis_rz
   input  wire logic [hjr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command
   input  wire logic [hjr_pkg::CMD_W-1:0]         req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // out_x, out_y, out_z, out_rx, out_ry, out_rz, out_buttons, status, zero fill
   output logic [hjr_pkg::RSP_DATA_W-1:0]         rsp_tdata
);
   import hjr_pkg::*;

   localparam int RSP_USED_W = NUM_AXES * AXIS_OUT_W + BUTTON_BITS + STATUS_W;

   logic                         accept;
   logic                         take;
   cmd_type                      command;
   logic [7:0]                   button_index;
   logic [7:0]                   button_mask;
   btn_result_type               lane_result [BUTTON_BITS];
   logic [NUM_AXES*AXIS_OUT_W-1:0] axes_out;
   button_byte_type              buttons_out;
   status_type                   status;
   logic [RSP_DATA_W-1:0]        word_in;

   logic                         out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0]        out_data_ff, out_data_in;
   logic                         skid_valid_ff, skid_valid_in;
   logic [RSP_DATA_W-1:0]        skid_data_ff, skid_data_in;

   assign req_tready   = !skid_valid_ff;
   assign accept       = req_tvalid && req_tready;
   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign take         = out_valid_ff && rsp_tready;

   assign command      = req_tuser;
   assign button_index = req_tdata[7:0];
   assign button_mask  = req_tdata[15:8];

   for (genvar b = 0; b < BUTTON_BITS; b++) begin : g_button
      if (b < NUM_BUTTONS) begin : g_lane
         hjr_button_lane #(
            .LANE_INDEX (b)
         ) u_lane (
            .clock        (clock),
            .reset        (reset),
            .accept       (accept),
            .command      (command),
            .button_index (button_index),
            .button_mask  (button_mask),
            .result       (lane_result[b])
         );
      end else begin : g_unused
         assign lane_result[b] = '0;
      end
   end

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      hjr_axis_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .accept     (accept),
         .command    (command),
         .axis_value (req_tdata[2*BUTTON_BITS + a*AXIS_IN_W +: AXIS_IN_W]),
         .axis_out   (axes_out[a*AXIS_OUT_W +: AXIS_OUT_W])
      );
   end

   hjr_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .command      (command),
      .button_index (button_index),
      .lane_result  (lane_result),
      .buttons_out  (buttons_out),
      .status       (status)
   );

   assign word_in = {{(RSP_DATA_W-RSP_USED_W){1'b0}}, status, buttons_out, axes_out};

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = word_in;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = word_in;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule
`default_nettype wire

// File: hw/rtl/hjr_button_lane.sv
`default_nettype none
module hjr_button_lane #(
   parameter int LANE_INDEX = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire hjr_pkg::cmd_type       command,
   input  wire logic [7:0]             button_index,
   input  wire logic [7:0]             button_mask,
   output hjr_pkg::btn_result_type     result
);
   import hjr_pkg::*;

   count_type count_ff, count_in;
   logic      held_ff, held_in;
   logic      single_hit;
   logic      press_hit;
   logic      release_hit;
   logic      count_zero;

   assign single_hit  = (button_index == 8'(LANE_INDEX));
   assign press_hit   = ((command == CMD_PRESS) && single_hit) ||
                        ((command == CMD_PRESS_MASK) && button_mask[LANE_INDEX]);
   assign release_hit = ((command == CMD_RELEASE) && single_hit) ||
                        ((command == CMD_RELEASE_MASK) && button_mask[LANE_INDEX]);
   assign count_zero  = (count_ff == '0);

   always_comb begin
      count_in         = count_ff;
      held_in          = held_ff;
      result.success   = 1'b0;
      result.underflow = 1'b0;
      if (press_hit) begin
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 8'd1;
         end
         held_in        = 1'b1;
         result.success = 1'b1;
      end else if (release_hit) begin
         if (count_zero) begin
            result.underflow = (command == CMD_RELEASE);
         end else begin
            count_in       = count_ff - 8'd1;
            result.success = 1'b1;
            if (count_ff == 8'd1) begin
               held_in = 1'b0;
            end
         end
      end
      result.held = held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         held_ff  <= 1'b0;
      end else if (accept) begin
         count_ff <= count_in;
         held_ff  <= held_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/hjr_axis_lane.sv
`default_nettype none
module hjr_axis_lane (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   accept,
   input  wire hjr_pkg::cmd_type                       command,
   input  wire logic signed [hjr_pkg::AXIS_IN_W-1:0]   axis_value,
   output logic signed [hjr_pkg::AXIS_OUT_W-1:0]       axis_out
);
   import hjr_pkg::*;

   logic signed [AXIS_OUT_W-1:0] axis_ff, axis_in;
   logic signed [AXIS_SUM_W-1:0] base;
   logic signed [AXIS_SUM_W-1:0] sum;
   logic signed [AXIS_SUM_W-1:0] clamped;

   // Set uses a zero base, so set and add share one adder and clamp.
   assign base = (command == CMD_ADD_AXES) ?
                 {{(AXIS_SUM_W-AXIS_OUT_W){axis_ff[AXIS_OUT_W-1]}}, axis_ff} : '0;
   assign sum  = base + {axis_value[AXIS_IN_W-1], axis_value};

   always_comb begin
      if (sum > AXIS_MAX) begin
         clamped = AXIS_MAX;
      end else if (sum < AXIS_MIN) begin
         clamped = AXIS_MIN;
      end else begin
         clamped = sum;
      end
   end

   always_comb begin
      unique case (command)
         CMD_SET_AXES, CMD_ADD_AXES: axis_in = clamped[AXIS_OUT_W-1:0];
         CMD_CLEAR:                  axis_in = '0;
         default:                    axis_in = axis_ff;
      endcase
   end

   assign axis_out = axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= '0;
      end else if (accept) begin
         axis_ff <= axis_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/hjr_merge.sv
`default_nettype none
module hjr_merge #(
   parameter int NUM_BUTTONS = hjr_pkg::NUM_BUTTONS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire hjr_pkg::cmd_type        command,
   input  wire logic [7:0]              button_index,
   input  wire hjr_pkg::btn_result_type lane_result [hjr_pkg::BUTTON_BITS],
   output hjr_pkg::button_byte_type     buttons_out,
   output hjr_pkg::status_type          status
);
   import hjr_pkg::*;

   button_byte_type report_ff, report_in;
   button_byte_type held_mask;
   logic            any_success;
   logic            any_underflow;
   logic            index_ok;

   always_comb begin
      any_success   = 1'b0;
      any_underflow = 1'b0;
      for (int b = 0; b < BUTTON_BITS; b++) begin
         held_mask[b]  = lane_result[b].held;
         any_success   = any_success | lane_result[b].success;
         any_underflow = any_underflow | lane_result[b].underflow;
      end
   end

   assign index_ok = (button_index < 8'(NUM_BUTTONS));

   always_comb begin
      priority if (command == CMD_CLEAR) begin
         report_in = '0;
      end else if (any_success) begin
         report_in = held_mask;
      end else begin
         report_in = report_ff;
      end
   end

   always_comb begin
      status = STATUS_OK;
      if ((command == CMD_PRESS) || (command == CMD_RELEASE)) begin
         if (!index_ok) begin
            status = STATUS_BAD_INDEX;
         end else if (any_underflow) begin
            status = STATUS_UNDERFLOW;
         end
      end
   end

   assign buttons_out = report_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         report_ff <= '0;
      end else if (accept) begin
         report_ff <= report_in;
      end
   end

endmodule
`default_nettype wire

// File: sim/tb_hid_joystick_report_accumulator_core.sv
`timescale 1ns / 1ps
module tb_hid_joystick_report_accumulator_core;
   import hjr_pkg::*;

   localparam int NBTN         = NUM_BUTTONS_DEF;
   localparam int RANDOM_ITEMS = 1425;
   localparam int PHASE_LEN    = 480;
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 60;

   typedef struct packed {
      logic [NUM_AXES-1:0][AXIS_IN_W-1:0] axis;
      logic [BUTTON_BITS-1:0]             mask;
      logic [BUTTON_BITS-1:0]             index;
      cmd_type                            cmd;
   } joy_item_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   hid_joystick_report_accumulator_core #(.NUM_BUTTONS(NBTN)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Predicted state of the report.
   count_type              press_count [NBTN];
   logic [BUTTON_BITS-1:0] held_bits;
   logic [BUTTON_BITS-1:0] report_btn;
   logic signed [7:0]      report_axis [NUM_AXES];

   joy_item_t       pending_q [$];
   logic [63:0]     report_q [$];
   joy_item_t       cur_item;
   joy_item_t       next_item;
   logic [63:0]     want;
   int              req_count = 0;
   int              rsp_count = 0;
   int              errors = 0;
   int              quiet_cycles = 0;
   int              hold_left = 0;
   bit              hold_done = 1'b0;
   int              tx_idle_pct;
   int              rx_idle_pct;

   assign tx_idle_pct = (req_count < PHASE_LEN) ? 22 : (req_count < 2 * PHASE_LEN) ? 76 : 0;
   assign rx_idle_pct = (req_count < PHASE_LEN) ? 76 : (req_count < 2 * PHASE_LEN) ? 22 : 0;

   function automatic bit press_button(input int b);
      if (press_count[b] != COUNT_MAX) press_count[b] = press_count[b] + 8'd1;
      held_bits[b] = 1'b1;
      report_btn   = held_bits;
      return 1'b1;
   endfunction

   function automatic bit release_button(input int b);
      if (press_count[b] == 8'd0) return 1'b0;
      press_count[b] = press_count[b] - 8'd1;
      if (press_count[b] == 8'd0) held_bits[b] = 1'b0;
      report_btn = held_bits;
      return 1'b1;
   endfunction

   // Applies one word to the predicted state and returns the expected response.
   function automatic logic [63:0] apply_item(input joy_item_t it);
      status_type st;
      int         v;
      logic [63:0] w;
      st = STATUS_OK;
      case (it.cmd)
         CMD_PRESS: begin
            if (it.index < NBTN) void'(press_button(it.index));
            else st = STATUS_BAD_INDEX;
         end
         CMD_RELEASE: begin
            if (it.index >= NBTN) st = STATUS_BAD_INDEX;
            else if (!release_button(it.index)) st = STATUS_UNDERFLOW;
         end
         CMD_PRESS_MASK, CMD_RELEASE_MASK: begin
            for (int i = 0; i < NBTN; i++) begin
               if (it.mask[i]) begin
                  if (it.cmd == CMD_PRESS_MASK) void'(press_button(i));
                  else void'(release_button(i));
               end
            end
         end
         CMD_SET_AXES, CMD_ADD_AXES: begin
            for (int i = 0; i < NUM_AXES; i++) begin
               v = int'($signed(it.axis[i]));
               if (it.cmd == CMD_ADD_AXES) v = v + int'(report_axis[i]);
               if (v > 127) v = 127;
               if (v < -127) v = -127;
               report_axis[i] = v[7:0];
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < NUM_AXES; i++) report_axis[i] = '0;
            report_btn = '0;
         end
         default: ;
      endcase
      w = '0;
      for (int i = 0; i < NUM_AXES; i++) w[8*i +: 8] = report_axis[i];
      w[55:48] = report_btn;
      w[57:56] = st;
      return w;
   endfunction

   task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   function automatic logic [15:0] rand_axis();
      int r;
      r = $urandom_range(99);
      if (r < 45) return 16'(int'($urandom_range(300)) - 150);
      if (r < 75) return 16'(int'($urandom_range(80)) - 40);
      return 16'($urandom);
   endfunction

   function automatic joy_item_t rand_item();
      joy_item_t it;
      it.cmd   = cmd_type'($urandom_range(7));
      it.index = ($urandom_range(99) < 75) ? 8'($urandom_range(NBTN - 1)) : 8'($urandom);
      it.mask  = 8'($urandom);
      for (int i = 0; i < NUM_AXES; i++) it.axis[i] = rand_axis();
      return it;
   endfunction

   function automatic joy_item_t make_item(input cmd_type c, input logic [7:0] idx,
                                           input logic [7:0] m,
                                           input logic [NUM_AXES-1:0][AXIS_IN_W-1:0] a);
      joy_item_t it;
      it.cmd   = c;
      it.index = idx;
      it.mask  = m;
      it.axis  = a;
      return it;
   endfunction

   task automatic push_cmd(input cmd_type c, input logic [7:0] idx, input logic [7:0] m);
      joy_item_t it;
      it       = rand_item();
      it.cmd   = c;
      it.index = idx;
      it.mask  = m;
      pending_q.push_back(it);
   endtask

   // Sender: one word is offered at a time and held until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            report_q.push_back(apply_item(cur_item));
            req_count <= req_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               next_item = pending_q.pop_front();
               cur_item   <= next_item;
               req_tvalid <= 1'b1;
               req_tdata  <= {next_item.axis, next_item.mask, next_item.index};
               req_tuser  <= next_item.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off that backs the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && rsp_count >= 1100) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count <= rsp_count + 1;
         if (report_q.size() == 0) begin
            $display("%0t: response %0h arrived with nothing expected", $time, rsp_tdata);
            errors++;
         end else begin
            want = report_q.pop_front();
            check_field("out_x", want[7:0], rsp_tdata[7:0]);
            check_field("out_y", want[15:8], rsp_tdata[15:8]);
            check_field("out_z", want[23:16], rsp_tdata[23:16]);
            check_field("out_rx", want[31:24], rsp_tdata[31:24]);
            check_field("out_ry", want[39:32], rsp_tdata[39:32]);
            check_field("out_rz", want[47:40], rsp_tdata[47:40]);
            check_field("out_buttons", want[55:48], rsp_tdata[55:48]);
            check_field("status", 8'(want[57:56]), 8'(rsp_tdata[57:56]));
            check_field("fill", 8'(want[63:58]), 8'(rsp_tdata[63:58]));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int n;
      int b;
      int k;
      bit sat_done;

      for (int i = 0; i < NBTN; i++) press_count[i] = '0;
      for (int i = 0; i < NUM_AXES; i++) report_axis[i] = '0;
      held_bits  = '0;
      report_btn = '0;

      pending_q.push_back(make_item(CMD_PRESS, 8'd0, 8'h00, '0));
      pending_q.push_back(make_item(CMD_PRESS, 8'd7, 8'hFF, {6{16'hFFFF}}));
      pending_q.push_back(make_item(CMD_PRESS, 8'd8, 8'h00, '0));
      pending_q.push_back(make_item(CMD_PRESS, 8'd255, 8'h00, '0));
      pending_q.push_back(make_item(CMD_RELEASE, 8'd7, 8'h00, '0));
      // Second release of the same button finds its count at zero.
      pending_q.push_back(make_item(CMD_RELEASE, 8'd7, 8'h00, '0));
      pending_q.push_back(make_item(CMD_RELEASE, 8'd255, 8'h00, '0));
      pending_q.push_back(make_item(CMD_RELEASE, 8'd8, 8'h00, '0));
      pending_q.push_back(make_item(CMD_PRESS_MASK, 8'd0, 8'hFF, '0));
      pending_q.push_back(make_item(CMD_PRESS_MASK, 8'd0, 8'h00, '0));
      pending_q.push_back(make_item(CMD_RELEASE_MASK, 8'd0, 8'hAA, '0));
      pending_q.push_back(make_item(CMD_RELEASE_MASK, 8'd0, 8'hFF, '0));
      // Only button 0 still has a count here, so its release clears the last held bit.
      pending_q.push_back(make_item(CMD_RELEASE_MASK, 8'd0, 8'hFF, '0));
      pending_q.push_back(make_item(CMD_SET_AXES, 8'd0, 8'h00, {6{16'h7FFF}}));
      pending_q.push_back(make_item(CMD_SET_AXES, 8'd0, 8'h00, {6{16'h8000}}));
      pending_q.push_back(make_item(CMD_SET_AXES, 8'd0, 8'h00,
         {16'hFFFF, 16'h0000, 16'hFF80, 16'h0080, 16'hFF81, 16'h007F}));
      pending_q.push_back(make_item(CMD_ADD_AXES, 8'd0, 8'h00, {6{16'h7FFF}}));
      pending_q.push_back(make_item(CMD_ADD_AXES, 8'd0, 8'h00, {6{16'h8000}}));
      pending_q.push_back(make_item(CMD_ADD_AXES, 8'd0, 8'h00,
         {16'hFF81, 16'h007F, 16'hFF38, 16'h00C8, 16'hFFFF, 16'h0001}));
      pending_q.push_back(make_item(CMD_PRESS, 8'd3, 8'h00, '0));
      // Clear keeps the counts and held bits, so the next press shows them again.
      pending_q.push_back(make_item(CMD_CLEAR, 8'd0, 8'h00, {6{16'h1234}}));
      pending_q.push_back(make_item(cmd_type'(3'd7), 8'd0, 8'hFF, {6{16'h0042}}));
      pending_q.push_back(make_item(CMD_PRESS_MASK, 8'd0, 8'h81, '0));
      pending_q.push_back(make_item(CMD_RELEASE, 8'd3, 8'h00, '0));
      pending_q.push_back(make_item(CMD_CLEAR, 8'd0, 8'h00, '0));

      sat_done = 1'b0;
      n = 0;
      while (n < RANDOM_ITEMS) begin
         if (!sat_done && n >= 400) begin
            // Drive every count into saturation, then all the way back and one past zero.
            for (int i = 0; i < 258; i++) push_cmd(CMD_PRESS_MASK, 8'($urandom), 8'hFF);
            for (int i = 0; i < 256; i++) push_cmd(CMD_RELEASE_MASK, 8'($urandom), 8'hFF);
            n += 514;
            sat_done = 1'b1;
         end else if ($urandom_range(99) < 25) begin
            b = $urandom_range(NBTN - 1);
            k = $urandom_range(4, 1);
            for (int i = 0; i < k; i++) push_cmd(CMD_PRESS, 8'(b), 8'($urandom));
            k = k + $urandom_range(1);
            for (int i = 0; i < k; i++) push_cmd(CMD_RELEASE, 8'(b), 8'($urandom));
            n += 2 * k;
         end else begin
            pending_q.push_back(rand_item());
            n++;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_tvalid || report_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: hid_joystick_report_accumulator_core.f
hw/rtl/hjr_pkg.sv
hw/rtl/hjr_button_lane.sv
hw/rtl/hjr_axis_lane.sv
hw/rtl/hjr_merge.sv
hw/rtl/hid_joystick_report_accumulator_core.sv
sim/tb_hid_joystick_report_accumulator_core.sv
